// ----- sv/assert_macros.svh -----
// assertion helpers for the scheduler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ----- sv/sts_pkg.sv -----
package sts_pkg;

  // table and semaphore sizes
  localparam int SYSTEM_TASKS = 2;
  localparam int USER_PROCS = 6;
  localparam int SEM_COUNT = 4;
  localparam int TABLE_SIZE = SYSTEM_TASKS + USER_PROCS;
  localparam int RING_W = (USER_PROCS > 1) ? $clog2(USER_PROCS) : 1;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_SETCNT = 3'd1,
    CMD_SINIT  = 3'd2,
    CMD_WAIT   = 3'd3,
    CMD_SIGNAL = 3'd4,
    CMD_SLEEP  = 3'd5,
    CMD_SCHED  = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_t;

  // classified command passed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic        ent_ok;
    logic        sem_ok;
    logic [2:0]  ent;
    logic [1:0]  si;
    logic [15:0] word;
    logic [23:0] slp;
    logic [10:0] secs;
    logic        flag;
  } op_t;

  typedef struct packed {
    logic [2:0]  current_task;
    logic        none_ready;
    logic [7:0]  sem_count;
    logic [2:0]  woken_task;
    logic        woken_valid;
    logic        caller_blocked;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_REFILL, ST_SCAN2, ST_MUL, ST_DONE
  } state_t;

  localparam logic [23:0] MAX24 = 24'hFFFFFF;
  // milliseconds to seconds: multiply by 2^29/1000 rounded up, exact for 20 bits
  localparam logic [19:0] MS_RECIP = 20'd536871;
  localparam int MS_SHIFT = 29;
  localparam int unsigned SLEEP_FIX = 10;

endpackage

// ----- sv/sts_front.sv -----
module sts_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    command,
  input  logic [2:0]    entry_index,
  input  logic [1:0]    sem_index,
  input  logic [15:0]   word_value,
  input  logic [23:0]   sleep_count,
  input  logic [19:0]   duration_ms,
  input  logic          sleep_flag,
  output logic          q_valid,
  output sts_pkg::op_t  q_op,
  input  logic          q_take
);

  // two entry queue between classify and execute
  sts_pkg::op_t slot [2];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  sts_pkg::op_t op_in;
  logic do_push;
  logic [39:0] ms_scaled;

  // whole seconds by reciprocal multiplication
  assign ms_scaled = 40'(duration_ms) * 40'(sts_pkg::MS_RECIP);

  // classify the incoming command
  always_comb begin
    op_in.cmd    = sts_pkg::cmd_t'(command);
    op_in.ent_ok = 32'(entry_index) < sts_pkg::TABLE_SIZE;
    op_in.sem_ok = 32'(sem_index) < sts_pkg::SEM_COUNT;
    op_in.ent    = entry_index;
    op_in.si     = sem_index;
    op_in.word   = word_value;
    op_in.slp    = sleep_count;
    op_in.secs   = ms_scaled[sts_pkg::MS_SHIFT+10:sts_pkg::MS_SHIFT];
    op_in.flag   = sleep_flag;
  end

  assign full = cnt == 2'd2;
  assign do_push = push && !full;
  assign q_valid = cnt != 2'd0;
  assign q_op = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= op_in;
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (q_take) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(q_take);
    end
  end

endmodule

// ----- sv/sts_back.sv -----
module sts_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [9:0]    tick_rate,
  input  logic          q_valid,
  input  sts_pkg::op_t  q_op,
  output logic          q_take,
  output logic          empty,
  input  logic          pop,
  output sts_pkg::res_t res
);

  localparam int USER_PROCS = sts_pkg::USER_PROCS;
  localparam int SEM_COUNT = sts_pkg::SEM_COUNT;
  localparam int TABLE_SIZE = sts_pkg::TABLE_SIZE;
  localparam int RW = sts_pkg::RING_W;

  sts_pkg::state_t state, state_next;
  sts_pkg::op_t op;
  logic [15:0] prio_store [TABLE_SIZE];
  logic [15:0] tick_store [TABLE_SIZE];
  logic [23:0] sleep_store [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] blocked_marks, sleep_mode_marks;
  logic [2:0] running_task;
  logic signed [7:0] sem_counts [SEM_COUNT];
  logic [2:0] wait_rings [SEM_COUNT][USER_PROCS];
  logic [RW-1:0] ring_heads [SEM_COUNT];
  logic [RW-1:0] ring_tails [SEM_COUNT];
  logic [3:0] idx;
  logic [15:0] best;
  logic [2:0] best_idx;
  logic [23:0] prod;
  logic out_full;
  logic [2:0] r_task;
  logic r_none, r_wv, r_blk;
  logic [2:0] r_wt;
  logic [7:0] r_cnt;
  logic w_none, w_wv, w_blk;
  logic [2:0] w_wt;
  logic [7:0] w_cnt;

  logic [2:0] ei;
  logic [1:0] si;
  logic signed [7:0] c_cur;
  logic [RW-1:0] hd, tl;
  logic scan_ok;
  logic [33:0] full_prod;

  assign ei = op.ent;
  assign si = op.si;
  assign c_cur = sem_counts[si];
  assign hd = ring_heads[si];
  assign tl = ring_tails[si];
  assign scan_ok = sleep_store[idx[2:0]] == '0 && !blocked_marks[idx[2:0]]
                   && tick_store[idx[2:0]] > best;
  assign full_prod = 34'(op.secs) * 34'(tick_rate) * 34'(sts_pkg::SLEEP_FIX);
  assign q_take = state == sts_pkg::ST_IDLE && q_valid;
  assign empty = !out_full;
  assign res = '{r_task, r_none, r_cnt, r_wt, r_wv, r_blk};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sts_pkg::ST_IDLE: if (q_valid) state_next = sts_pkg::ST_EXEC;
      sts_pkg::ST_EXEC: begin
        unique case (op.cmd)
          sts_pkg::CMD_WAIT:
            state_next = (op.sem_ok && (c_cur - 8'sd1) < 0 && c_cur != -8'sd128)
                         || (op.sem_ok && c_cur == -8'sd128)
                         ? sts_pkg::ST_SCAN : sts_pkg::ST_DONE;
          sts_pkg::CMD_SLEEP: state_next = sts_pkg::ST_MUL;
          sts_pkg::CMD_SCHED: state_next = sts_pkg::ST_SCAN;
          default: state_next = sts_pkg::ST_DONE;
        endcase
      end
      sts_pkg::ST_MUL: state_next = sts_pkg::ST_SCAN;
      sts_pkg::ST_SCAN:
        if (idx == 4'(TABLE_SIZE)) state_next = best != '0 ? sts_pkg::ST_DONE
                                                          : sts_pkg::ST_REFILL;
      sts_pkg::ST_REFILL: state_next = sts_pkg::ST_SCAN2;
      sts_pkg::ST_SCAN2: if (idx == 4'(TABLE_SIZE)) state_next = sts_pkg::ST_DONE;
      sts_pkg::ST_DONE: if (!out_full) state_next = sts_pkg::ST_IDLE;
      default: state_next = sts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sts_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (q_take) op <= q_op;
  end

  // table, semaphores and scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        prio_store[i] <= '0;
        tick_store[i] <= '0;
        sleep_store[i] <= '0;
      end
      for (int s = 0; s < SEM_COUNT; s++) begin
        sem_counts[s] <= '0;
        ring_heads[s] <= '0;
        ring_tails[s] <= '0;
      end
      blocked_marks <= '0;
      sleep_mode_marks <= '0;
      running_task <= '0;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        sts_pkg::ST_IDLE: begin
          w_none <= 1'b0;
          w_cnt <= '0;
          w_wt <= '0;
          w_wv <= 1'b0;
          w_blk <= 1'b0;
          idx <= '0;
          best <= '0;
        end
        sts_pkg::ST_EXEC: begin
          unique case (op.cmd)
            sts_pkg::CMD_LOAD: if (op.ent_ok) prio_store[ei] <= op.word;
            sts_pkg::CMD_SETCNT: if (op.ent_ok) begin
              tick_store[ei] <= op.word;
              sleep_store[ei] <= op.slp;
            end
            sts_pkg::CMD_SINIT: if (op.sem_ok) begin
              sem_counts[si] <= op.word > 16'd127 ? 8'sd127 : 8'(op.word);
              w_cnt <= op.word > 16'd127 ? 8'd127 : 8'(op.word);
              ring_heads[si] <= '0;
              ring_tails[si] <= '0;
            end
            sts_pkg::CMD_WAIT: if (op.sem_ok) begin
              sem_counts[si] <= c_cur == -8'sd128 ? c_cur : c_cur - 8'sd1;
              w_cnt <= c_cur == -8'sd128 ? c_cur : c_cur - 8'sd1;
              if (c_cur <= 8'sd0) begin
                blocked_marks[running_task] <= 1'b1;
                wait_rings[si][tl] <= running_task;
                ring_tails[si] <= 32'(tl) == USER_PROCS - 1 ? '0 : tl + 1'b1;
                w_blk <= 1'b1;
              end
            end
            sts_pkg::CMD_SIGNAL: if (op.sem_ok) begin
              sem_counts[si] <= c_cur == 8'sd127 ? c_cur : c_cur + 8'sd1;
              w_cnt <= c_cur == 8'sd127 ? c_cur : c_cur + 8'sd1;
              if (c_cur < 8'sd0) begin
                blocked_marks[wait_rings[si][hd]] <= 1'b0;
                w_wt <= wait_rings[si][hd];
                w_wv <= 1'b1;
                ring_heads[si] <= 32'(hd) == USER_PROCS - 1 ? '0 : hd + 1'b1;
              end
            end
            default: ;
          endcase
          prod <= full_prod > 34'(sts_pkg::MAX24) ? sts_pkg::MAX24 : 24'(full_prod);
        end
        sts_pkg::ST_MUL: begin
          sleep_store[running_task] <= prod;
          sleep_mode_marks[running_task] <= op.flag;
        end
        sts_pkg::ST_SCAN, sts_pkg::ST_SCAN2: begin
          if (idx != 4'(TABLE_SIZE)) begin
            if (scan_ok) begin
              best <= tick_store[idx[2:0]];
              best_idx <= idx[2:0];
            end
            idx <= idx + 4'd1;
          end else begin
            if (best != '0) running_task <= best_idx;
            else if (state == sts_pkg::ST_SCAN2) w_none <= 1'b1;
            idx <= '0;
          end
        end
        sts_pkg::ST_REFILL: begin
          for (int i = 0; i < TABLE_SIZE; i++)
            if (tick_store[i] == '0) tick_store[i] <= prio_store[i];
        end
        // result register only loads once the previous result has left
        sts_pkg::ST_DONE: if (!out_full) begin
          out_full <= 1'b1;
          r_task <= running_task;
          r_none <= w_none;
          r_cnt <= w_cnt;
          r_wt <= w_wt;
          r_wv <= w_wv;
          r_blk <= w_blk;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/semaphore_task_scheduler_core.sv -----
// a command passes through the two-entry input queue, then the back end runs
// exec and done for table and semaphore commands; a blocking wait, sleep or
// schedule adds a table scan (sleep after a multiply step), and a refill and second scan when none is ready
// throughput: one command at a time, set by the serial eight-entry scan
// rst (synchronous, active high) clears the table, semaphores and queues
// tick_rate resets to 100
`include "assert_macros.svh"
module semaphore_task_scheduler_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [9:0]        cfg_wdata,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        command,
  input  logic [2:0]        entry_index,
  input  logic [1:0]        sem_index,
  input  logic [15:0]       word_value,
  input  logic [23:0]       sleep_count,
  input  logic [19:0]       duration_ms,
  input  logic              sleep_flag,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        current_task,
  output logic              none_ready,
  output logic signed [7:0] sem_count,
  output logic [2:0]        woken_task,
  output logic              woken_valid,
  output logic              caller_blocked
);

  logic [9:0] tick_rate;
  logic q_valid, q_take;
  sts_pkg::op_t q_op;
  sts_pkg::res_t res;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) tick_rate <= 10'd100;
    else if (cfg_we) tick_rate <= cfg_wdata;
  end

  sts_front u_front (
    .clk, .rst, .push, .full, .command, .entry_index, .sem_index,
    .word_value, .sleep_count, .duration_ms, .sleep_flag,
    .q_valid, .q_op, .q_take
  );

  sts_back u_back (
    .clk, .rst, .tick_rate, .q_valid, .q_op, .q_take, .empty, .pop, .res
  );

  assign current_task   = res.current_task;
  assign none_ready     = res.none_ready;
  assign sem_count      = res.sem_count;
  assign woken_task     = res.woken_task;
  assign woken_valid    = res.woken_valid;
  assign caller_blocked = res.caller_blocked;

  // a result never reports both a wake and a block
  `CHK_IMPL(a_wake_block, !empty, !(woken_valid && caller_blocked))
  // a result that stays unpopped stays present and keeps its current task
  `CHK_NEXT(a_hold, !empty && !pop, $stable(current_task) && !empty)
  // the back end takes from the queue only when it holds something
  `CHK_IMPL(a_take, q_take, q_valid)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int N_ENT = 8;
  localparam int N_SEM = 4;
  localparam int RING = 6;
  localparam int N_RAND = 1500;
  localparam int DRAIN = 40;
  localparam longint LIMIT = 1500000;

  typedef struct {
    sts_pkg::cmd_t cmd;
    logic [2:0]  ent;
    logic [1:0]  si;
    logic [15:0] word;
    logic [23:0] slp;
    logic [19:0] ms;
    logic        flag;
  } kcmd_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [9:0]        cfg_wdata;
  logic              push;
  logic              full;
  logic [2:0]        command;
  logic [2:0]        entry_index;
  logic [1:0]        sem_index;
  logic [15:0]       word_value;
  logic [23:0]       sleep_count;
  logic [19:0]       duration_ms;
  logic              sleep_flag;
  logic              empty;
  logic              pop;
  logic [2:0]        current_task;
  logic              none_ready;
  logic signed [7:0] sem_count;
  logic [2:0]        woken_task;
  logic              woken_valid;
  logic              caller_blocked;

  semaphore_task_scheduler_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .command(command), .entry_index(entry_index),
    .sem_index(sem_index), .word_value(word_value), .sleep_count(sleep_count),
    .duration_ms(duration_ms), .sleep_flag(sleep_flag), .empty(empty), .pop(pop),
    .current_task(current_task), .none_ready(none_ready), .sem_count(sem_count),
    .woken_task(woken_task), .woken_valid(woken_valid),
    .caller_blocked(caller_blocked)
  );

  // scheduler shadow state
  logic [9:0]  rate_m;
  logic [15:0] prio_m [N_ENT];
  logic [15:0] ticks_m [N_ENT];
  logic [23:0] sleep_m [N_ENT];
  bit          blocked_m [N_ENT];
  bit          mode_m [N_ENT];
  logic [2:0]  run_m;
  int          count_m [N_SEM];
  logic [2:0]  ring_m [N_SEM][RING];
  bit          ring_wr [N_SEM][RING];
  int          head_m [N_SEM];
  int          tail_m [N_SEM];

  sts_pkg::res_t outcome_q [$];
  int     errors = 0;
  int     n_sent = 0;
  int     n_got = 0;
  int     n_wake = 0;
  int     n_block = 0;
  int     n_idle_sched = 0;
  longint cycles = 0;
  longint pop_cycles = 0;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // one scan of the table, lowest index wins ties
  function automatic bit scan_table();
    int unsigned best;
    best = 0;
    for (int i = 0; i < N_ENT; i++) begin
      if (sleep_m[i] != 0 || blocked_m[i]) continue;
      if (ticks_m[i] > best) begin
        best = ticks_m[i];
        run_m = i[2:0];
      end
    end
    return best != 0;
  endfunction

  // returns 1 when nothing could run
  function automatic bit pick_task();
    if (scan_table()) return 0;
    for (int i = 0; i < N_ENT; i++)
      if (ticks_m[i] == 0) ticks_m[i] = prio_m[i];
    return !scan_table();
  endfunction

  function automatic sts_pkg::res_t apply_command(kcmd_t c);
    sts_pkg::res_t r;
    int cnt;
    longint t;
    int s;
    r = '0;
    cnt = 0;
    s = c.si;
    case (c.cmd)
      sts_pkg::CMD_LOAD: prio_m[c.ent] = c.word;
      sts_pkg::CMD_SETCNT: begin
        ticks_m[c.ent] = c.word;
        sleep_m[c.ent] = c.slp;
      end
      sts_pkg::CMD_SINIT: begin
        count_m[s] = (c.word > 127) ? 127 : c.word;
        head_m[s] = 0;
        tail_m[s] = 0;
        cnt = count_m[s];
      end
      sts_pkg::CMD_WAIT: begin
        if (count_m[s] > -128) count_m[s]--;
        cnt = count_m[s];
        if (cnt < 0) begin
          blocked_m[run_m] = 1;
          ring_m[s][tail_m[s]] = run_m;
          ring_wr[s][tail_m[s]] = 1;
          tail_m[s] = (tail_m[s] + 1) % RING;
          r.caller_blocked = 1;
          r.none_ready = pick_task();
        end
      end
      sts_pkg::CMD_SIGNAL: begin
        if (count_m[s] < 127) count_m[s]++;
        cnt = count_m[s];
        if (cnt <= 0) begin
          r.woken_task = ring_m[s][head_m[s]];
          blocked_m[r.woken_task] = 0;
          head_m[s] = (head_m[s] + 1) % RING;
          r.woken_valid = 1;
        end
      end
      sts_pkg::CMD_SLEEP: begin
        t = longint'(c.ms / 1000) * rate_m * 10;
        if (t > sts_pkg::MAX24) t = sts_pkg::MAX24;
        sleep_m[run_m] = t[23:0];
        mode_m[run_m] = c.flag;
        r.none_ready = pick_task();
      end
      sts_pkg::CMD_SCHED: r.none_ready = pick_task();
      default: ;
    endcase
    r.current_task = run_m;
    r.sem_count = cnt[7:0];
    return r;
  endfunction

  // a signal may never read a ring slot that was never written
  function automatic kcmd_t guard_ring(kcmd_t c);
    int s;
    int nc;
    s = c.si;
    if (c.cmd == sts_pkg::CMD_SIGNAL) begin
      nc = (count_m[s] < 127) ? count_m[s] + 1 : count_m[s];
      if (nc <= 0 && !ring_wr[s][head_m[s]]) c.cmd = sts_pkg::CMD_SCHED;
    end
    return c;
  endfunction

  function automatic kcmd_t mk(sts_pkg::cmd_t cmd, int ent, int si, int word, int slp,
                               int ms, int flag);
    kcmd_t c;
    c.cmd = cmd;
    c.ent = ent[2:0];
    c.si = si[1:0];
    c.word = word[15:0];
    c.slp = slp[23:0];
    c.ms = ms[19:0];
    c.flag = flag[0];
    return c;
  endfunction

  function automatic kcmd_t rand_command();
    kcmd_t c;
    int w;
    c = mk(sts_pkg::CMD_NOP, $urandom_range(7), $urandom_range(3), 0, 0, 0,
           $urandom_range(1));
    c.word = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    c.slp = ($urandom_range(5) == 0) ? 24'($urandom) : 24'd0;
    c.ms = ($urandom_range(4) == 0) ? 20'($urandom) : 20'($urandom_range(2500));
    w = $urandom_range(99);
    if (w < 10) c.cmd = sts_pkg::CMD_LOAD;
    else if (w < 25) c.cmd = sts_pkg::CMD_SETCNT;
    else if (w < 30) c.cmd = sts_pkg::CMD_SINIT;
    else if (w < 50) c.cmd = sts_pkg::CMD_WAIT;
    else if (w < 70) c.cmd = sts_pkg::CMD_SIGNAL;
    else if (w < 77) c.cmd = sts_pkg::CMD_SLEEP;
    else if (w < 98) c.cmd = sts_pkg::CMD_SCHED;
    return c;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(15) == 0) ? $urandom_range(60, 20) : $urandom_range(2);
  endfunction

  // one input transfer, expectation queued on acceptance
  task automatic send(kcmd_t c, bit typed, sts_pkg::res_t typed_res);
    sts_pkg::res_t r;
    int g;
    c = guard_ring(c);
    r = apply_command(c);
    if (typed) r = typed_res;
    push <= 1;
    command <= c.cmd;
    entry_index <= c.ent;
    sem_index <= c.si;
    word_value <= c.word;
    sleep_count <= c.slp;
    duration_ms <= c.ms;
    sleep_flag <= c.flag;
    do @(posedge clk); while (full);
    outcome_q.push_back(r);
    n_sent++;
    g = gap_len();
    if (g > 0) begin
      push <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic settle();
    push <= 0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_rate(logic [9:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    rate_m = v;
  endtask

  // result side with random stalls and one long hold-off
  always @(posedge clk) begin
    pop_cycles <= pop_cycles + 1;
    if (rst) begin
      pop <= 0;
    end else if (pop_cycles > 3000 && pop_cycles < 3600) begin
      pop <= 0;
    end else if ($urandom_range(15) == 0) begin
      pop <= 0;
    end else begin
      pop <= ($urandom_range(3) != 0);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    sts_pkg::res_t e;
    if (!rst && pop && !empty) begin
      n_got++;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result transfer, task %0d", $time, current_task);
        errors++;
      end else begin
        e = outcome_q.pop_front();
        if (e.woken_valid) n_wake++;
        if (e.caller_blocked) n_block++;
        if (e.none_ready) n_idle_sched++;
        if (current_task !== e.current_task) begin
          $display("%0t: current_task exp %0d got %0d", $time, e.current_task, current_task);
          errors++;
        end
        if (none_ready !== e.none_ready) begin
          $display("%0t: none_ready exp %0d got %0d", $time, e.none_ready, none_ready);
          errors++;
        end
        if (sem_count !== e.sem_count) begin
          $display("%0t: sem_count exp %0d got %0d", $time, $signed(e.sem_count),
                   sem_count);
          errors++;
        end
        if (woken_task !== e.woken_task) begin
          $display("%0t: woken_task exp %0d got %0d", $time, e.woken_task, woken_task);
          errors++;
        end
        if (woken_valid !== e.woken_valid) begin
          $display("%0t: woken_valid exp %0d got %0d", $time, e.woken_valid, woken_valid);
          errors++;
        end
        if (caller_blocked !== e.caller_blocked) begin
          $display("%0t: caller_blocked exp %0d got %0d", $time, e.caller_blocked,
                   caller_blocked);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, outcome_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    kcmd_t dir_tbl [$];
    bit    dir_typed [$];
    sts_pkg::res_t dir_res [$];
    sts_pkg::res_t tr;
    logic [9:0] rates [4];

    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    push = 0;
    command = sts_pkg::CMD_NOP;
    entry_index = '0;
    sem_index = '0;
    word_value = '0;
    sleep_count = '0;
    duration_ms = '0;
    sleep_flag = 0;

    rate_m = 10'd100;
    run_m = '0;
    for (int i = 0; i < N_ENT; i++) begin
      prio_m[i] = '0;
      ticks_m[i] = '0;
      sleep_m[i] = '0;
      blocked_m[i] = 0;
      mode_m[i] = 0;
    end
    for (int s = 0; s < N_SEM; s++) begin
      count_m[s] = 0;
      head_m[s] = 0;
      tail_m[s] = 0;
      for (int k = 0; k < RING; k++) begin
        ring_m[s][k] = '0;
        ring_wr[s][k] = 0;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 0;

    // directed rows; typed results only where obvious
    tr = '0;
    tr.none_ready = 1;
    dir_tbl.push_back(mk(sts_pkg::CMD_SCHED, 0, 0, 0, 0, 0, 0)); dir_typed.push_back(1);
    dir_res.push_back(tr);
    tr = '0;
    tr.sem_count = 8'd127;
    dir_tbl.push_back(mk(sts_pkg::CMD_SINIT, 0, 1, 65535, 0, 0, 0));
    dir_typed.push_back(1); dir_res.push_back(tr);
    dir_tbl.push_back(mk(sts_pkg::CMD_SIGNAL, 0, 1, 0, 0, 0, 0));
    dir_typed.push_back(1); dir_res.push_back(tr);
    tr = '0;
    dir_tbl.push_back(mk(sts_pkg::CMD_NOP, 7, 3, 65535, 16777215, 1048575, 1));
    dir_typed.push_back(1); dir_res.push_back(tr);
    dir_tbl.push_back(mk(sts_pkg::CMD_LOAD, 0, 0, 5, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_LOAD, 3, 0, 65535, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_LOAD, 7, 0, 1, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_LOAD, 2, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SETCNT, 5, 0, 65535, 16777215, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SCHED, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SETCNT, 5, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SINIT, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_WAIT, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_WAIT, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SIGNAL, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SIGNAL, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SIGNAL, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SLEEP, 0, 0, 0, 0, 1048575, 1));
    dir_tbl.push_back(mk(sts_pkg::CMD_SLEEP, 0, 0, 0, 0, 999, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SETCNT, 3, 0, 7, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SCHED, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(sts_pkg::CMD_SINIT, 0, 2, 0, 0, 0, 0));
    while (dir_typed.size() < dir_tbl.size()) begin
      dir_typed.push_back(0);
      dir_res.push_back('0);
    end
    for (int i = 0; i < dir_tbl.size(); i++) send(dir_tbl[i], dir_typed[i], dir_res[i]);
    settle();

    // random phases at several tick rates
    rates[0] = 10'd1;
    rates[1] = 10'd1000;
    rates[2] = 10'($urandom_range(1000, 1));
    rates[3] = 10'd100;
    for (int p = 0; p < 4; p++) begin
      write_rate(rates[p]);
      // drive one semaphore to the negative limit, wrapping its ring
      if (p == 1) begin
        send(mk(sts_pkg::CMD_SINIT, 0, 3, 0, 0, 0, 0), 0, '0);
        repeat (130) send(mk(sts_pkg::CMD_WAIT, 0, 3, 0, 0, 0, 0), 0, '0);
        repeat (4) send(mk(sts_pkg::CMD_SIGNAL, 0, 3, 0, 0, 0, 0), 0, '0);
      end
      repeat (N_RAND / 4) send(rand_command(), 0, '0);
      settle();
    end

    $display("sent %0d commands, checked %0d results", n_sent, n_got);
    $display("wakeups %0d, blocking waits %0d, idle schedules %0d",
             n_wake, n_block, n_idle_sched);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sts_pkg.sv
sv/sts_front.sv
sv/sts_back.sv
sv/semaphore_task_scheduler_core.sv
tb/testbench.sv
